// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TBRH_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TBRH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TBRH_ASSERT(lbl, clk, rst_n, prop, msg)
`define TBRH_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/tbrh_pkg.sv -----
// ----------------------------------------------------------------------------
// Time bucket rate histogram package
// Field widths, time constants, item kinds and parameter defaults.
// ----------------------------------------------------------------------------
package tbrh_pkg;

    localparam int HOURS_DEF            = 24;
    localparam int MINUTES_PER_HOUR_DEF = 60;
    localparam int BUCKET_BITS_DEF      = 16;

    localparam int SECONDS_PER_MINUTE = 60;
    localparam int SLOTS_PER_SECOND   = 10;
    localparam int MS_PER_SLOT        = 100;
    localparam int MS_PER_SECOND      = SLOTS_PER_SECOND * MS_PER_SLOT;
    localparam int BUCKETS_PER_MINUTE = SECONDS_PER_MINUTE * SLOTS_PER_SECOND;

    // floor(ms / 100) == (ms * 41) >> 12 for ms below 1000
    localparam int MS_RECIP       = 41;
    localparam int MS_RECIP_SHIFT = 12;

    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int SECOND_W  = 6;
    localparam int MS_W      = 10;
    localparam int CFG_W     = 16;
    localparam int EVENT_W   = 32;
    localparam int OFF_W     = 10;
    localparam int DEV_OUT_W = 16;
    localparam int SLOT_W    = 10;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

endpackage

// ----- rtl/tbrh_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tbrh_ram #(
    parameter int  WIDTH  = 16,
    parameter int  DEPTH  = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/tbrh_div.sv -----
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tbrh_div #(
    parameter int DIVIDEND_W = 26,
    parameter int DIVISOR_W  = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_divisor;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W:0]    w_trial;
    logic [DIVISOR_W:0]    w_diff;
    logic                  w_fit;

    assign w_trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_divisor};
    assign w_diff  = w_trial - {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_divisor <= i_divisor;
            r_rem     <= '0;
            r_quo     <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    `TBRH_ASSERT(a_done_pulse, i_clk, i_rst_n, o_done |=> !o_done, "done longer than one cycle")
    `TBRH_ASSERT(a_start_busy, i_clk, i_rst_n, i_start |=> r_busy, "start did not engage divider")
    `TBRH_ASSERT(a_busy_cnt, i_clk, i_rst_n, r_busy |-> (r_cnt != '0), "busy with empty count")

endmodule

// ----- rtl/time_bucket_rate_histogram_unit.sv -----
// ----------------------------------------------------------------------------
// Time bucket rate histogram unit
// Per-minute and per-100 ms event counters in RAM; queries scan one minute.
//
//   channel   handshake                 payload
//   input     start / busy              i_kind, i_hour, i_minute, i_second,
//                                       i_millisecond
//   config    i_cfg_valid / o_cfg_ready i_cfg_data (expected per bucket)
//   result    o_done strobe             o_minute_events, o_present,
//                                       o_off_buckets, o_*_deviation
//
// Record: address, read and write back steps run before the next accept.
// Query: time from accept to next accept is set by the single bucket RAM read
// port (one bucket a cycle) and the bit-serial divider; out-of-range queries
// return to idle straight after the address step.
// Reset: clearing pass over every bucket and minute address with busy high;
// configuration writes are taken throughout.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module time_bucket_rate_histogram_unit
    import tbrh_pkg::*;
#(
    parameter int HOURS            = HOURS_DEF,
    parameter int MINUTES_PER_HOUR = MINUTES_PER_HOUR_DEF,
    parameter int BUCKET_BITS      = BUCKET_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [0:0]           i_kind,
    input  logic [HOUR_W-1:0]    i_hour,
    input  logic [MINUTE_W-1:0]  i_minute,
    input  logic [SECOND_W-1:0]  i_second,
    input  logic [MS_W-1:0]      i_millisecond,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_done,
    output logic [EVENT_W-1:0]   o_minute_events,
    output logic [0:0]           o_present,
    output logic [OFF_W-1:0]     o_off_buckets,
    output logic [DEV_OUT_W-1:0] o_mean_deviation,
    output logic [DEV_OUT_W-1:0] o_min_deviation,
    output logic [DEV_OUT_W-1:0] o_max_deviation
);

    localparam int MINUTE_TOTAL = HOURS * MINUTES_PER_HOUR;
    localparam int BUCKET_TOTAL = MINUTE_TOTAL * BUCKETS_PER_MINUTE;
    localparam int MIN_AW = (MINUTE_TOTAL > 1) ? $clog2(MINUTE_TOTAL) : 1;
    localparam int BKT_AW = $clog2(BUCKET_TOTAL);
    localparam int DEV_W  = (BUCKET_BITS > CFG_W) ? BUCKET_BITS : CFG_W;
    localparam int SUM_W  = DEV_W + OFF_W;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_ADDR  = 8'b0000_0100,
        S_RD    = 8'b0000_1000,
        S_WR    = 8'b0001_0000,
        S_SCAN  = 8'b0010_0000,
        S_DRAIN = 8'b0100_0000,
        S_DIV   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [BKT_AW-1:0]      r_clr_idx;
    logic [CFG_W-1:0]       r_expected;
    logic                   r_kind;
    logic [HOUR_W-1:0]      r_hour;
    logic [MINUTE_W-1:0]    r_minute;
    logic [SECOND_W-1:0]    r_second;
    logic [MS_W-1:0]        r_ms;
    logic                   r_ok;
    logic [MIN_AW-1:0]      r_midx;
    logic [SLOT_W-1:0]      r_slot;
    logic [BKT_AW-1:0]      r_base;
    logic [BKT_AW-1:0]      r_baddr;
    logic [SLOT_W-1:0]      r_scan;
    logic                   r_rd_vld;
    logic                   r_dev_vld;
    logic                   r_dev_off;
    logic [DEV_W-1:0]       r_dev;
    logic [OFF_W-1:0]       r_off_cnt;
    logic [SUM_W-1:0]       r_sum;
    logic [DEV_W-1:0]       r_min;
    logic [DEV_W-1:0]       r_max;
    logic [EVENT_W-1:0]     r_events;
    logic                   r_done;
    logic [EVENT_W-1:0]     r_o_events;
    logic [OFF_W-1:0]       r_o_off;
    logic [DEV_OUT_W-1:0]   r_o_mean;
    logic [DEV_OUT_W-1:0]   r_o_min;
    logic [DEV_OUT_W-1:0]   r_o_max;

    logic                   w_min_ok;
    logic                   w_rec_ok;
    logic [MIN_AW-1:0]      w_midx;
    logic [2*MS_W-1:0]      w_ms_prod;
    logic [SLOT_W-1:0]      w_slot;
    logic [BKT_AW-1:0]      w_base;
    logic                   w_finish;
    logic                   w_bad_query;

    logic                   w_min_we;
    logic [MIN_AW-1:0]      w_min_waddr;
    logic [EVENT_W-1:0]     w_min_wdata;
    logic [EVENT_W-1:0]     w_min_rdata;
    logic                   w_bkt_we;
    logic [BKT_AW-1:0]      w_bkt_waddr;
    logic [BUCKET_BITS-1:0] w_bkt_wdata;
    logic [BKT_AW-1:0]      w_bkt_raddr;
    logic [BUCKET_BITS-1:0] w_bkt_rdata;

    logic [DEV_W-1:0]       w_c;
    logic [DEV_W-1:0]       w_e;
    logic [DEV_W-1:0]       w_dev;
    logic                   w_off;

    logic                   w_div_start;
    logic                   w_div_done;
    logic [SUM_W-1:0]       w_div_quo;

    function automatic logic [DEV_OUT_W-1:0] f_cap(input logic [SUM_W-1:0] v);
        return (v > SUM_W'({DEV_OUT_W{1'b1}})) ? {DEV_OUT_W{1'b1}} : v[DEV_OUT_W-1:0];
    endfunction

    // address arithmetic
    assign w_min_ok  = (int'(r_hour) < HOURS) && (int'(r_minute) < MINUTES_PER_HOUR);
    assign w_rec_ok  = w_min_ok && (int'(r_second) < SECONDS_PER_MINUTE)
                     && (int'(r_ms) < MS_PER_SECOND);
    assign w_midx    = MIN_AW'(r_hour) * MIN_AW'(MINUTES_PER_HOUR) + MIN_AW'(r_minute);
    assign w_ms_prod = (2*MS_W)'(r_ms) * (2*MS_W)'(MS_RECIP);
    assign w_slot    = SLOT_W'(r_second) * SLOT_W'(SLOTS_PER_SECOND)
                     + SLOT_W'(w_ms_prod >> MS_RECIP_SHIFT);
    assign w_base    = BKT_AW'(r_midx) * BKT_AW'(BUCKETS_PER_MINUTE);

    assign w_bad_query = (r_state == S_ADDR) && (r_kind == KIND_QUERY) && !w_min_ok;
    assign w_finish    = w_bad_query || ((r_state == S_DIV) && w_div_done);
    assign w_div_start = (r_state == S_DRAIN) && !r_rd_vld && !r_dev_vld;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == BKT_AW'(BUCKET_TOTAL - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) n_state = S_ADDR;
            end
            S_ADDR: begin
                n_state = w_bad_query ? S_IDLE : S_RD;
            end
            S_RD: begin
                n_state = (r_kind == KIND_RECORD) ? S_WR : S_SCAN;
            end
            S_WR: begin
                n_state = S_IDLE;
            end
            S_SCAN: begin
                if (r_scan == SLOT_W'(BUCKETS_PER_MINUTE - 1)) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (w_div_start) n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // memory ports
    assign w_min_we    = ((r_state == S_CLEAR) && (r_clr_idx < BKT_AW'(MINUTE_TOTAL)))
                       || ((r_state == S_WR) && r_ok);
    assign w_min_waddr = (r_state == S_CLEAR) ? r_clr_idx[MIN_AW-1:0] : r_midx;
    assign w_min_wdata = (r_state == S_CLEAR) ? '0
                       : (&w_min_rdata) ? w_min_rdata : w_min_rdata + EVENT_W'(1);

    assign w_bkt_we    = (r_state == S_CLEAR) || ((r_state == S_WR) && r_ok);
    assign w_bkt_waddr = (r_state == S_CLEAR) ? r_clr_idx : r_baddr;
    assign w_bkt_wdata = (r_state == S_CLEAR) ? '0
                       : (&w_bkt_rdata) ? w_bkt_rdata : w_bkt_rdata + BUCKET_BITS'(1);
    assign w_bkt_raddr = (r_state == S_SCAN) ? r_base + BKT_AW'(r_scan)
                                             : w_base + BKT_AW'(r_slot);

    tbrh_ram #(
        .WIDTH (EVENT_W),
        .DEPTH (MINUTE_TOTAL)
    ) u_minute_ram (
        .i_clk   (i_clk),
        .i_we    (w_min_we),
        .i_waddr (w_min_waddr),
        .i_wdata (w_min_wdata),
        .i_raddr (r_midx),
        .o_rdata (w_min_rdata)
    );

    tbrh_ram #(
        .WIDTH (BUCKET_BITS),
        .DEPTH (BUCKET_TOTAL)
    ) u_bucket_ram (
        .i_clk   (i_clk),
        .i_we    (w_bkt_we),
        .i_waddr (w_bkt_waddr),
        .i_wdata (w_bkt_wdata),
        .i_raddr (w_bkt_raddr),
        .o_rdata (w_bkt_rdata)
    );

    // deviation of one bucket
    assign w_c   = DEV_W'(w_bkt_rdata);
    assign w_e   = DEV_W'(r_expected);
    assign w_off = (w_c != '0) && (w_c != w_e);
    assign w_dev = (w_c > w_e) ? w_c - w_e : w_e - w_c;

    tbrh_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (OFF_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_off_cnt),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_idx  <= '0;
            r_expected <= '0;
            r_rd_vld   <= 1'b0;
            r_dev_vld  <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= (r_state == S_SCAN);
            r_dev_vld <= r_rd_vld;
            r_done    <= w_finish;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + BKT_AW'(1);
            end
            if (i_cfg_valid) begin
                r_expected <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && start) begin
            r_kind   <= i_kind;
            r_hour   <= i_hour;
            r_minute <= i_minute;
            r_second <= i_second;
            r_ms     <= i_millisecond;
        end
        if (r_state == S_ADDR) begin
            r_midx <= w_midx;
            r_slot <= w_slot;
            r_ok   <= w_rec_ok;
        end
        if (r_state == S_RD) begin
            r_base    <= w_base;
            r_baddr   <= w_base + BKT_AW'(r_slot);
            r_scan    <= '0;
            r_off_cnt <= '0;
            r_sum     <= '0;
            r_min     <= '0;
            r_max     <= '0;
        end
        if (r_state == S_SCAN) begin
            r_scan <= r_scan + SLOT_W'(1);
            if (r_scan == '0) begin
                r_events <= w_min_rdata;
            end
        end
        if (r_rd_vld) begin
            r_dev     <= w_dev;
            r_dev_off <= w_off;
        end
        if (r_dev_vld && r_dev_off) begin
            r_off_cnt <= r_off_cnt + OFF_W'(1);
            r_sum     <= r_sum + SUM_W'(r_dev);
            if ((r_off_cnt == '0) || (r_dev < r_min)) r_min <= r_dev;
            if ((r_off_cnt == '0) || (r_dev > r_max)) r_max <= r_dev;
        end
        if (w_finish) begin
            if (w_bad_query) begin
                r_o_events <= '0;
                r_o_off    <= '0;
                r_o_mean   <= '0;
                r_o_min    <= '0;
                r_o_max    <= '0;
            end else begin
                r_o_events <= r_events;
                r_o_off    <= r_off_cnt;
                r_o_mean   <= (r_off_cnt == '0) ? '0 : f_cap(w_div_quo);
                r_o_min    <= f_cap(SUM_W'(r_min));
                r_o_max    <= f_cap(SUM_W'(r_max));
            end
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_done           = r_done;
    assign o_minute_events  = r_o_events;
    assign o_present        = (r_o_events != '0);
    assign o_off_buckets    = r_o_off;
    assign o_mean_deviation = r_o_mean;
    assign o_min_deviation  = r_o_min;
    assign o_max_deviation  = r_o_max;

    `TBRH_ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> ((r_state == S_CLEAR) && !o_done), "reset did not start clearing")
    `TBRH_ASSERT(a_done_idle, i_clk, i_rst_n, o_done |-> !busy, "result strobed while busy")
    `TBRH_ASSERT(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "accepted item left unit idle")
    `TBRH_ASSERT(a_bkt_write, i_clk, i_rst_n, w_bkt_we |-> ((r_state == S_CLEAR) || (r_state == S_WR)), "bucket write outside clear or write back")

endmodule

// ----- verif/time_bucket_rate_histogram_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time bucket rate histogram unit testbench
// Feeds record and query items through the start/busy port and keeps its own
// minute and bucket tallies to work out every query summary. Summaries are
// compared with each o_done strobe in order. The expected per-bucket count
// is rewritten between phases, only once the unit has gone quiet.
// ----------------------------------------------------------------------------
module time_bucket_rate_histogram_unit_tb;
    import tbrh_pkg::*;

    localparam int MINUTES_PER_DAY = HOURS_DEF * MINUTES_PER_HOUR_DEF;
    localparam int CYCLE_LIMIT     = 6_000_000;
    localparam int SETTLE_CYCLES   = 700;
    localparam int QUIET_CYCLES    = 8;
    localparam int CALM_TAIL       = 60;
    localparam int REPORT_LIMIT    = 10;
    localparam longint unsigned DEV_CAP = 65535;

    typedef struct {
        logic                kind;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic [MS_W-1:0]     millisecond;
    } t_stamp;

    typedef struct packed {
        logic [EVENT_W-1:0]   events;
        logic                 present;
        logic [OFF_W-1:0]     offs;
        logic [DEV_OUT_W-1:0] mean;
        logic [DEV_OUT_W-1:0] lo;
        logic [DEV_OUT_W-1:0] hi;
    } t_summary;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [0:0]           i_kind = '0;
    logic [HOUR_W-1:0]    i_hour = '0;
    logic [MINUTE_W-1:0]  i_minute = '0;
    logic [SECOND_W-1:0]  i_second = '0;
    logic [MS_W-1:0]      i_millisecond = '0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 o_done;
    logic [EVENT_W-1:0]   o_minute_events;
    logic [0:0]           o_present;
    logic [OFF_W-1:0]     o_off_buckets;
    logic [DEV_OUT_W-1:0] o_mean_deviation;
    logic [DEV_OUT_W-1:0] o_min_deviation;
    logic [DEV_OUT_W-1:0] o_max_deviation;

    t_stamp                      pending_stamps[$];
    t_summary                    minute_summaries[$];
    logic [EVENT_W-1:0]          minute_tally[MINUTES_PER_DAY];
    logic [BUCKET_BITS_DEF-1:0]  bucket_tally[int unsigned];
    logic [CFG_W-1:0]            expected_level = '0;
    t_stamp                      cur;
    int                          queued_total = 0;
    int                          accepted_total = 0;
    int                          mismatches = 0;
    int                          cycle_count = 0;
    int                          gap_left = 0;
    int                          gap_pct = 25;
    bit                          final_lap = 1'b0;
    int unsigned                 hot_minute[6];

    time_bucket_rate_histogram_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_kind           (i_kind),
        .i_hour           (i_hour),
        .i_minute         (i_minute),
        .i_second         (i_second),
        .i_millisecond    (i_millisecond),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_done           (o_done),
        .o_minute_events  (o_minute_events),
        .o_present        (o_present),
        .o_off_buckets    (o_off_buckets),
        .o_mean_deviation (o_mean_deviation),
        .o_min_deviation  (o_min_deviation),
        .o_max_deviation  (o_max_deviation)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [DEV_OUT_W-1:0] cap_dev(input longint unsigned v);
        return (v > DEV_CAP) ? DEV_CAP[DEV_OUT_W-1:0] : v[DEV_OUT_W-1:0];
    endfunction

    function automatic string describe(input t_summary s);
        return $sformatf("events=%0d present=%0d off=%0d mean=%0d min=%0d max=%0d",
                         s.events, s.present, s.offs, s.mean, s.lo, s.hi);
    endfunction

    task automatic post(input logic kind, input int h, input int m, input int s,
                        input int ms);
        t_stamp st;
        st.kind        = kind;
        st.hour        = h[HOUR_W-1:0];
        st.minute      = m[MINUTE_W-1:0];
        st.second      = s[SECOND_W-1:0];
        st.millisecond = ms[MS_W-1:0];
        pending_stamps.push_back(st);
        queued_total++;
    endtask

    task automatic queue_random(input int n);
        int roll;
        int idx;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
                roll = $urandom_range(0, 9);
                if (roll < 8) begin
                    idx = hot_minute[$urandom_range(0, 5)];
                    post(KIND_QUERY, idx / MINUTES_PER_HOUR_DEF, idx % MINUTES_PER_HOUR_DEF,
                         $urandom_range(0, 63), $urandom_range(0, 1023));
                end else if (roll == 8) begin
                    post(KIND_QUERY, $urandom_range(0, 23), $urandom_range(0, 59),
                         $urandom_range(0, 63), $urandom_range(0, 1023));
                end else if ($urandom_range(0, 1) == 0) begin
                    post(KIND_QUERY, $urandom_range(24, 31), $urandom_range(0, 63),
                         $urandom_range(0, 63), $urandom_range(0, 1023));
                end else begin
                    post(KIND_QUERY, $urandom_range(0, 23), $urandom_range(60, 63),
                         $urandom_range(0, 63), $urandom_range(0, 1023));
                end
            end else if (roll < 22) begin
                post(KIND_RECORD, $urandom_range(0, 31), $urandom_range(0, 63),
                     $urandom_range(0, 63), $urandom_range(0, 1023));
            end else begin
                idx = ($urandom_range(0, 9) < 9) ? hot_minute[$urandom_range(0, 5)]
                                                 : $urandom_range(0, MINUTES_PER_DAY - 1);
                post(KIND_RECORD, idx / MINUTES_PER_HOUR_DEF, idx % MINUTES_PER_HOUR_DEF,
                     ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(0, 59),
                     $urandom_range(0, 999));
            end
        end
    endtask

    task automatic drain();
        while (accepted_total != queued_total || minute_summaries.size() != 0)
            @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_expected(input logic [CFG_W-1:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        expected_level = v;
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin : feed
        t_summary        want;
        int unsigned     midx;
        int unsigned     bidx;
        int unsigned     offs;
        int              s;
        longint unsigned cnt;
        longint unsigned dev;
        longint unsigned sum;
        longint unsigned lo;
        longint unsigned hi;
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left = 0;
        end else begin
            if (start && !busy) begin
                midx = cur.hour * MINUTES_PER_HOUR_DEF + cur.minute;
                if (cur.kind == KIND_QUERY) begin
                    want = '0;
                    if (cur.hour < HOURS_DEF && cur.minute < MINUTES_PER_HOUR_DEF) begin
                        want.events  = minute_tally[midx];
                        want.present = (minute_tally[midx] != '0);
                        offs = 0;
                        sum  = 0;
                        lo   = 0;
                        hi   = 0;
                        for (s = 0; s < BUCKETS_PER_MINUTE; s++) begin
                            bidx = midx * BUCKETS_PER_MINUTE + s;
                            cnt  = bucket_tally.exists(bidx) ? bucket_tally[bidx] : 0;
                            if (cnt != 0 && cnt != expected_level) begin
                                dev = (cnt > expected_level) ? cnt - expected_level
                                                             : expected_level - cnt;
                                if (offs == 0 || dev < lo) lo = dev;
                                if (offs == 0 || dev > hi) hi = dev;
                                offs++;
                                sum += dev;
                            end
                        end
                        want.offs = offs[OFF_W-1:0];
                        if (offs != 0) begin
                            want.mean = cap_dev(sum / offs);
                            want.lo   = cap_dev(lo);
                            want.hi   = cap_dev(hi);
                        end
                    end
                    minute_summaries.push_back(want);
                end else if (cur.hour < HOURS_DEF && cur.minute < MINUTES_PER_HOUR_DEF &&
                             cur.second < SECONDS_PER_MINUTE &&
                             cur.millisecond < MS_PER_SECOND) begin
                    bidx = midx * BUCKETS_PER_MINUTE + cur.second * SLOTS_PER_SECOND
                         + cur.millisecond / MS_PER_SLOT;
                    if (minute_tally[midx] != '1)
                        minute_tally[midx] = minute_tally[midx] + 1'b1;
                    if (!bucket_tally.exists(bidx))
                        bucket_tally[bidx] = '0;
                    if (bucket_tally[bidx] != '1)
                        bucket_tally[bidx] = bucket_tally[bidx] + 1'b1;
                end
                accepted_total++;
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_stamps.size() == 0) begin
                    start <= 1'b0;
                end else begin
                    cur = pending_stamps.pop_front();
                    i_kind        <= cur.kind;
                    i_hour        <= cur.hour;
                    i_minute      <= cur.minute;
                    i_second      <= cur.second;
                    i_millisecond <= cur.millisecond;
                    start         <= 1'b1;
                    if (!(final_lap && pending_stamps.size() < CALM_TAIL) &&
                        $urandom_range(0, 99) < gap_pct)
                        gap_left = $urandom_range(1, 6);
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch
        t_summary got;
        t_summary want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end else if (i_rst_n && o_done) begin
            got.events  = o_minute_events;
            got.present = o_present;
            got.offs    = o_off_buckets;
            got.mean    = o_mean_deviation;
            got.lo      = o_min_deviation;
            got.hi      = o_max_deviation;
            if (minute_summaries.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("Unexpected result: %s", describe(got));
            end else begin
                want = minute_summaries.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("Result mismatch:\n  expected %s\n  actual   %s",
                                 describe(want), describe(got));
                end
            end
        end
    end

    initial begin : stimulus
        foreach (minute_tally[m]) minute_tally[m] = '0;
        hot_minute[0] = 0;
        hot_minute[1] = MINUTES_PER_DAY - 1;
        for (int h = 2; h < 6; h++) hot_minute[h] = $urandom_range(0, MINUTES_PER_DAY - 1);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (!busy) @(posedge i_clk);
        while (busy) @(posedge i_clk);

        write_expected('0);
        post(KIND_RECORD, 0, 0, 0, 0);
        post(KIND_RECORD, 0, 0, 0, 99);
        post(KIND_RECORD, 0, 0, 0, 100);
        post(KIND_RECORD, 0, 0, 59, 999);
        post(KIND_RECORD, 23, 59, 59, 999);
        post(KIND_RECORD, 23, 59, 0, 0);
        post(KIND_RECORD, 23, 59, 0, 50);
        post(KIND_RECORD, 24, 0, 0, 0);
        post(KIND_RECORD, 31, 63, 63, 1023);
        post(KIND_RECORD, 12, 60, 0, 0);
        post(KIND_RECORD, 12, 30, 60, 0);
        post(KIND_RECORD, 12, 30, 0, 1000);
        post(KIND_QUERY, 0, 0, 0, 0);
        post(KIND_QUERY, 23, 59, 63, 1023);
        post(KIND_QUERY, 12, 30, 0, 0);
        post(KIND_QUERY, 24, 0, 0, 0);
        post(KIND_QUERY, 31, 63, 63, 1023);
        post(KIND_QUERY, 0, 60, 0, 0);
        drain();

        write_expected(16'd1);
        post(KIND_QUERY, 0, 0, 0, 0);
        post(KIND_QUERY, 23, 59, 0, 0);
        queue_random(150);
        drain();

        gap_pct = 0;
        write_expected('1);
        queue_random(140);
        drain();

        gap_pct = 40;
        write_expected(16'd2);
        queue_random(150);
        drain();

        gap_pct = 20;
        write_expected(CFG_W'($urandom_range(3, 9)));
        queue_random(140);
        drain();

        gap_pct = 30;
        final_lap = 1'b1;
        write_expected(CFG_W'($urandom_range(0, 65535)));
        queue_random(150);
        while (accepted_total != queued_total || minute_summaries.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
